FILE: rtl/uart_rf_pkg.sv
// shared types, register codes and constants for the uart register file
`default_nettype none

package uart_rf_pkg;

    // default fifo depths
    localparam int unsigned RX_DEPTH_DEF = 16;
    localparam int unsigned TX_DEPTH_DEF = 16;

    // request function codes
    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_RX    = 2'd2;
    localparam logic [1:0] FUNC_TICK  = 2'd3;

    // register offsets
    localparam logic [2:0] ADDR_RBR = 3'd0;
    localparam logic [2:0] ADDR_IER = 3'd1;
    localparam logic [2:0] ADDR_IIR = 3'd2;
    localparam logic [2:0] ADDR_FCR = 3'd2;
    localparam logic [2:0] ADDR_LCR = 3'd3;
    localparam logic [2:0] ADDR_MCR = 3'd4;
    localparam logic [2:0] ADDR_LSR = 3'd5;
    localparam logic [2:0] ADDR_MSR = 3'd6;
    localparam logic [2:0] ADDR_SCR = 3'd7;

    // register bits and fixed values
    localparam int unsigned DLAB_BIT  = 7;
    localparam logic [7:0]  IER_MASK  = 8'h0F;
    localparam logic [7:0]  IIR_VALUE = 8'h01;
    localparam logic [7:0]  LSR_DR    = 8'h01;
    localparam logic [7:0]  LSR_THRE  = 8'h20;
    localparam logic [7:0]  LSR_TEMT  = 8'h40;
    localparam logic [7:0]  FCR_EN    = 8'h01;
    localparam logic [7:0]  FCR_RXCLR = 8'h02;
    localparam logic [7:0]  FCR_TXCLR = 8'h04;

    // one request as held in the input register
    typedef struct packed {
        logic [1:0] func;
        logic [2:0] reg_addr;
        logic [7:0] byte_in;
    } req_t;

    // one response as held in the output register
    typedef struct packed {
        logic [7:0] read_data;
        logic       rx_dropped;
        logic       tx_overflow;
        logic       tx_valid;
        logic [7:0] tx_byte;
    } rsp_t;

    // fifo control from the register file
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } fifo_cmd_t;

    // fifo status back to the register file
    typedef struct packed {
        logic empty;
        logic full;
        logic last;
    } fifo_stat_t;

endpackage

`default_nettype wire

FILE: rtl/uart_rf_req_if.sv
// request channel interface: valid, ready and the request payload
`default_nettype none

interface uart_rf_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [2:0] reg_addr;
    logic [7:0] byte_in;

    modport source (output valid, output func, output reg_addr, output byte_in, input ready);
    modport sink   (input valid, input func, input reg_addr, input byte_in, output ready);
endinterface

`default_nettype wire

FILE: rtl/uart_rf_rsp_if.sv
// response channel interface: valid, ready and the response payload
`default_nettype none

interface uart_rf_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       rx_dropped;
    logic       tx_overflow;
    logic       tx_valid;
    logic [7:0] tx_byte;

    modport source (output valid, output read_data, output rx_dropped, output tx_overflow,
                    output tx_valid, output tx_byte, input ready);
    modport sink   (input valid, input read_data, input rx_dropped, input tx_overflow,
                    input tx_valid, input tx_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/uart_rf_fifo.sv
// circular byte fifo with head pointer, fill count and registered head read
`default_nettype none

module uart_rf_fifo #(
    parameter int unsigned DEPTH = uart_rf_pkg::RX_DEPTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire uart_rf_pkg::fifo_cmd_t cmd,
    input  wire logic [7:0]             wr_data,
    output uart_rf_pkg::fifo_stat_t     stat,
    output logic [7:0]                  rd_data
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned SW = CW + 1;

    logic [7:0]    mem [DEPTH];
    logic [AW-1:0] head_reg;
    logic [AW-1:0] head_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [SW-1:0] tail_sum;
    logic [SW-1:0] tail_wrap;
    logic [AW-1:0] tail;
    logic [AW-1:0] head_inc;
    logic [7:0]    rd_reg;

    // write slot is head plus count, wrapped once
    always_comb
    begin
        tail_sum  = SW'(head_reg) + SW'(count_reg);
        tail_wrap = (tail_sum >= SW'(DEPTH)) ? (tail_sum - SW'(DEPTH)) : tail_sum;
        tail      = tail_wrap[AW-1:0];
        head_inc  = (head_reg == AW'(DEPTH - 1)) ? '0 : (head_reg + 1'b1);
    end

    // pointer and count update
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (cmd.clear)
        begin
            head_next  = '0;
            count_next = '0;
        end
        else if (cmd.push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.pop)
        begin
            head_next  = head_inc;
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // storage write
    always_ff @(posedge clk)
    begin
        if (cmd.push && !cmd.clear)
        begin
            mem[tail] <= wr_data;
        end
    end

    // head entry read ahead from the next head pointer, with bypass of a write to that slot
    always_ff @(posedge clk)
    begin
        if (cmd.push && !cmd.clear && (tail == head_next))
        begin
            rd_reg <= wr_data;
        end
        else
        begin
            rd_reg <= mem[head_next];
        end
    end

    assign rd_data    = rd_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.last  = (count_reg == CW'(1));

endmodule

`default_nettype wire

FILE: rtl/uart_rf_regs.sv
// register file decode: line control, divisor, status and fifo commands
`default_nettype none

module uart_rf_regs (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    work,
    input  wire uart_rf_pkg::req_t       req,
    input  wire uart_rf_pkg::fifo_stat_t rx_stat,
    input  wire uart_rf_pkg::fifo_stat_t tx_stat,
    input  wire logic [7:0]              rx_data,
    input  wire logic [7:0]              tx_data,
    output uart_rf_pkg::fifo_cmd_t       rx_cmd,
    output uart_rf_pkg::fifo_cmd_t       tx_cmd,
    output uart_rf_pkg::rsp_t            rsp,
    output logic                         dr,
    output logic                         thre,
    output logic                         temt
);

    logic [7:0] lcr_reg, lcr_next;
    logic [3:0] ier_reg, ier_next;
    logic [7:0] mcr_reg, mcr_next;
    logic [7:0] scr_reg, scr_next;
    logic [7:0] dll_reg, dll_next;
    logic [7:0] dlm_reg, dlm_next;
    logic       dr_reg, dr_next;
    logic       thre_reg, thre_next;
    logic       temt_reg, temt_next;
    logic       dlab;
    logic [7:0] lsr_value;

    assign dlab      = lcr_reg[uart_rf_pkg::DLAB_BIT];
    assign lsr_value = (dr_reg   ? uart_rf_pkg::LSR_DR   : 8'h00)
                     | (thre_reg ? uart_rf_pkg::LSR_THRE : 8'h00)
                     | (temt_reg ? uart_rf_pkg::LSR_TEMT : 8'h00);

    // single pass decode of one request
    always_comb
    begin
        lcr_next  = lcr_reg;
        ier_next  = ier_reg;
        mcr_next  = mcr_reg;
        scr_next  = scr_reg;
        dll_next  = dll_reg;
        dlm_next  = dlm_reg;
        dr_next   = dr_reg;
        thre_next = thre_reg;
        temt_next = temt_reg;
        rx_cmd    = '0;
        tx_cmd    = '0;
        rsp       = '0;
        if (work)
        begin
            case (req.func)
                uart_rf_pkg::FUNC_READ:
                begin
                    case (req.reg_addr)
                        uart_rf_pkg::ADDR_RBR:
                        begin
                            if (dlab)
                            begin
                                rsp.read_data = dll_reg;
                            end
                            else if (!rx_stat.empty)
                            begin
                                rsp.read_data = rx_data;
                                rx_cmd.pop    = 1'b1;
                                if (rx_stat.last)
                                begin
                                    dr_next = 1'b0;
                                end
                            end
                        end
                        uart_rf_pkg::ADDR_IER:
                            rsp.read_data = dlab ? dlm_reg : {4'b0000, ier_reg};
                        uart_rf_pkg::ADDR_IIR: rsp.read_data = uart_rf_pkg::IIR_VALUE;
                        uart_rf_pkg::ADDR_LCR: rsp.read_data = lcr_reg;
                        uart_rf_pkg::ADDR_MCR: rsp.read_data = mcr_reg;
                        uart_rf_pkg::ADDR_LSR: rsp.read_data = lsr_value;
                        uart_rf_pkg::ADDR_SCR: rsp.read_data = scr_reg;
                        default:               rsp.read_data = 8'h00;
                    endcase
                end
                uart_rf_pkg::FUNC_WRITE:
                begin
                    case (req.reg_addr)
                        uart_rf_pkg::ADDR_RBR:
                        begin
                            if (dlab)
                            begin
                                dll_next = req.byte_in;
                            end
                            else
                            begin
                                tx_cmd.push     = !tx_stat.full;
                                rsp.tx_overflow = tx_stat.full;
                                thre_next       = 1'b0;
                                temt_next       = 1'b0;
                            end
                        end
                        uart_rf_pkg::ADDR_IER:
                        begin
                            if (dlab)
                            begin
                                dlm_next = req.byte_in;
                            end
                            else
                            begin
                                ier_next = 4'(req.byte_in & uart_rf_pkg::IER_MASK);
                            end
                        end
                        uart_rf_pkg::ADDR_FCR:
                        begin
                            if ((req.byte_in & uart_rf_pkg::FCR_EN) != 8'h00)
                            begin
                                if ((req.byte_in & uart_rf_pkg::FCR_RXCLR) != 8'h00)
                                begin
                                    rx_cmd.clear = 1'b1;
                                    dr_next      = 1'b0;
                                end
                                if ((req.byte_in & uart_rf_pkg::FCR_TXCLR) != 8'h00)
                                begin
                                    tx_cmd.clear = 1'b1;
                                    thre_next    = 1'b1;
                                end
                            end
                        end
                        uart_rf_pkg::ADDR_LCR: lcr_next = req.byte_in;
                        uart_rf_pkg::ADDR_MCR: mcr_next = req.byte_in;
                        uart_rf_pkg::ADDR_SCR: scr_next = req.byte_in;
                        default:               lcr_next = lcr_reg;
                    endcase
                end
                uart_rf_pkg::FUNC_RX:
                begin
                    if (rx_stat.full)
                    begin
                        rsp.rx_dropped = 1'b1;
                    end
                    else
                    begin
                        rx_cmd.push = 1'b1;
                        dr_next     = 1'b1;
                    end
                end
                default:
                begin
                    // transmit tick
                    if (!tx_stat.empty)
                    begin
                        tx_cmd.pop   = 1'b1;
                        rsp.tx_valid = 1'b1;
                        rsp.tx_byte  = tx_data;
                    end
                    if (tx_stat.empty || tx_stat.last)
                    begin
                        thre_next = 1'b1;
                        temt_next = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcr_reg  <= '0;
            ier_reg  <= '0;
            mcr_reg  <= '0;
            scr_reg  <= '0;
            dll_reg  <= '0;
            dlm_reg  <= '0;
            dr_reg   <= 1'b0;
            thre_reg <= 1'b1;
            temt_reg <= 1'b1;
        end
        else
        begin
            lcr_reg  <= lcr_next;
            ier_reg  <= ier_next;
            mcr_reg  <= mcr_next;
            scr_reg  <= scr_next;
            dll_reg  <= dll_next;
            dlm_reg  <= dlm_next;
            dr_reg   <= dr_next;
            thre_reg <= thre_next;
            temt_reg <= temt_next;
        end
    end

    assign dr   = dr_reg;
    assign thre = thre_reg;
    assign temt = temt_reg;

endmodule

`default_nettype wire

FILE: rtl/uart_register_fifo_block.sv
// Top level of the 16550-style uart register file with rx and tx fifos.
// Timing: a request accepted at an edge is held in the input register and decoded from
//   there; its response is registered once the output register can take it.
// Throughput: one request per cycle; the input stalls only while an unaccepted response
//   sits in the output register.
// Reset: control registers, fifo pointers and counts clear, LSR reads 0x60;
//   fifo storage is not cleared and needs no clearing pass.
`default_nettype none

module uart_register_fifo_block #(
    parameter int unsigned RX_DEPTH = uart_rf_pkg::RX_DEPTH_DEF,
    parameter int unsigned TX_DEPTH = uart_rf_pkg::TX_DEPTH_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    uart_rf_req_if.sink    req,
    uart_rf_rsp_if.source  rsp
);

    uart_rf_pkg::req_t       req_reg;
    logic                    req_valid_reg;
    uart_rf_pkg::rsp_t       rsp_reg;
    uart_rf_pkg::rsp_t       rsp_next;
    logic                    rsp_valid_reg;
    logic                    work;
    uart_rf_pkg::fifo_cmd_t  rx_cmd;
    uart_rf_pkg::fifo_cmd_t  tx_cmd;
    uart_rf_pkg::fifo_stat_t rx_stat;
    uart_rf_pkg::fifo_stat_t tx_stat;
    logic [7:0]              rx_data;
    logic [7:0]              tx_data;
    logic                    dr;
    logic                    thre;
    logic                    temt;

    // decode runs when a request is held and the output register can take it
    assign work      = req_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !req_valid_reg || work;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            req_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            req_reg.func     <= req.func;
            req_reg.reg_addr <= req.reg_addr;
            req_reg.byte_in  <= req.byte_in;
        end
    end

    uart_rf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .work    (work),
        .req     (req_reg),
        .rx_stat (rx_stat),
        .tx_stat (tx_stat),
        .rx_data (rx_data),
        .tx_data (tx_data),
        .rx_cmd  (rx_cmd),
        .tx_cmd  (tx_cmd),
        .rsp     (rsp_next),
        .dr      (dr),
        .thre    (thre),
        .temt    (temt)
    );

    uart_rf_fifo #(.DEPTH(RX_DEPTH)) u_rx_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (rx_cmd),
        .wr_data (req_reg.byte_in),
        .stat    (rx_stat),
        .rd_data (rx_data)
    );

    uart_rf_fifo #(.DEPTH(TX_DEPTH)) u_tx_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (tx_cmd),
        .wr_data (req_reg.byte_in),
        .stat    (tx_stat),
        .rd_data (tx_data)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (work)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (work)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.read_data   = rsp_reg.read_data;
    assign rsp.rx_dropped  = rsp_reg.rx_dropped;
    assign rsp.tx_overflow = rsp_reg.tx_overflow;
    assign rsp.tx_valid    = rsp_reg.tx_valid;
    assign rsp.tx_byte     = rsp_reg.tx_byte;

    // data ready tracks a non-empty receive fifo
    a_dr_tracks_rx: assert property (@(posedge clk) disable iff (!rst_n)
        dr == !rx_stat.empty)
        else $error("DR out of step with receive fifo");

    // transmitter empty never without holding register empty
    a_temt_thre: assert property (@(posedge clk) disable iff (!rst_n)
        temt |-> thre)
        else $error("TEMT set while THRE clear");

    // a fifo is never popped empty
    a_no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(rx_cmd.pop && rx_stat.empty) && !(tx_cmd.pop && tx_stat.empty))
        else $error("pop from empty fifo");

    // a receive clear leaves the fifo empty
    a_rx_clear: assert property (@(posedge clk) disable iff (!rst_n)
        rx_cmd.clear |=> rx_stat.empty)
        else $error("receive fifo not empty after clear");

endmodule

`default_nettype wire
